// ===== rtl/mpe_pkg.sv =====
// Shared constants, codes, types and helper functions of the matrix product engine.
`timescale 1ns / 1ps
`default_nettype none

package mpe_pkg;

    // Matrix geometry and element format
    localparam int MAX_DIM   = 16;
    localparam int ELEM_BITS = 16;

    // Fixed field widths of the channels
    localparam int OP_BITS      = 2;
    localparam int IDX_BITS     = 4;
    localparam int VALUE_BITS   = 16;
    localparam int PROD_BITS    = 36;
    localparam int SIZE_BITS    = 5;
    localparam int REG_IDX_BITS = 2;

    // Derived storage geometry
    localparam int RAM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_BITS = $clog2(RAM_DEPTH);
    localparam int DIM_BITS  = $clog2(MAX_DIM);
    localparam int MUL_BITS  = 2 * ELEM_BITS;

    // Request opcodes; the fourth code is ignored
    typedef enum logic [OP_BITS-1:0] {
        OP_WR_A = 2'd0,
        OP_WR_B = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_a;        // write beat for A
        logic wr_b;        // write beat for B
        logic start_read;  // product request accepted
        logic issue;       // fetch the next term
        logic load_out;    // move result into output register
    } mpe_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;        // incoming request needs no terms
        logic last_term;   // current term is the last one
        logic pipe_busy;   // terms still in flight
    } mpe_sts_t;

    // Register value limited to the storage size
    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] r);
        return (r > SIZE_BITS'(MAX_DIM)) ? SIZE_BITS'(MAX_DIM) : r;
    endfunction

    // Storage address of element (row, col)
    function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [IDX_BITS-1:0] r,
                                                       input logic [IDX_BITS-1:0] c);
        return ADDR_BITS'(r) * ADDR_BITS'(MAX_DIM) + ADDR_BITS'(c);
    endfunction

    // Input value sign extended, then cut to the element width
    function automatic logic signed [ELEM_BITS-1:0] to_elem(
        input logic signed [VALUE_BITS-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[ELEM_BITS-1:0];
    endfunction

    // Term product brought to the accumulator width
    function automatic logic [PROD_BITS-1:0] to_acc(input logic signed [MUL_BITS-1:0] p);
        logic signed [63:0] w;
        w = 64'(p);
        return w[PROD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mpe_if.sv =====
// Channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface mpe_req_if import mpe_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [OP_BITS-1:0]           op;
    logic [IDX_BITS-1:0]          row_index;
    logic [IDX_BITS-1:0]          col_index;
    logic signed [VALUE_BITS-1:0] elem_value;

    modport source (output valid, op, row_index, col_index, elem_value, input ready);
    modport sink   (input valid, op, row_index, col_index, elem_value, output ready);
endinterface

interface mpe_rsp_if import mpe_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [IDX_BITS-1:0]         out_row;
    logic [IDX_BITS-1:0]         out_col;
    logic signed [PROD_BITS-1:0] product_value;
    logic                        status;

    modport source (output valid, out_row, out_col, product_value, status, input ready);
    modport sink   (input valid, out_row, out_col, product_value, status, output ready);
endinterface

interface mpe_cfg_if import mpe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REG_IDX_BITS-1:0] reg_index;
    logic [SIZE_BITS-1:0]    reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mpe_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/mpe_datapath.sv =====
// Datapath: size registers, element stores, multiply-accumulate and result register.
`timescale 1ns / 1ps
`default_nettype none

module mpe_datapath import mpe_pkg::*; (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request payload
    input  wire logic [IDX_BITS-1:0]          row_index,
    input  wire logic [IDX_BITS-1:0]          col_index,
    input  wire logic signed [VALUE_BITS-1:0] elem_value,
    // result payload
    output logic [IDX_BITS-1:0]               out_row,
    output logic [IDX_BITS-1:0]               out_col,
    output logic signed [PROD_BITS-1:0]       product_value,
    output logic                              status,
    // configuration writes
    mpe_cfg_if.sink                           cfg,
    // control
    input  wire mpe_cmd_t                     cmd,
    output mpe_sts_t                          sts
);

    logic [SIZE_BITS-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [SIZE_BITS-1:0] nr, nk, nc;

    logic [IDX_BITS-1:0]  req_row_reg, req_col_reg;
    logic                 oob_reg;
    logic [DIM_BITS-1:0]  k_reg;

    logic                 data_v_reg, prod_v_reg;
    logic signed [MUL_BITS-1:0]  prod_reg;
    logic [PROD_BITS-1:0]        acc_reg;

    logic                 a_in_range, b_in_range, req_oob;
    logic [ELEM_BITS-1:0] a_rdata, b_rdata;
    logic [ADDR_BITS-1:0] a_raddr, b_raddr, wr_addr;
    logic [ELEM_BITS-1:0] wr_elem;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= SIZE_BITS'(MAX_DIM);
            inner_dim_reg <= SIZE_BITS'(MAX_DIM);
            cols_b_reg    <= SIZE_BITS'(MAX_DIM);
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg.reg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg.reg_data;
                REG_COLS_B:    cols_b_reg    <= cfg.reg_data;
                default:       ;
            endcase
        end
    end

    assign nr = eff_size(rows_a_reg);
    assign nk = eff_size(inner_dim_reg);
    assign nc = eff_size(cols_b_reg);

    // Range checks on the incoming beat
    assign a_in_range = (SIZE_BITS'(row_index) < nr) && (SIZE_BITS'(col_index) < nk);
    assign b_in_range = (SIZE_BITS'(row_index) < nk) && (SIZE_BITS'(col_index) < nc);
    assign req_oob    = (SIZE_BITS'(row_index) >= nr) || (SIZE_BITS'(col_index) >= nc);

    assign wr_addr = elem_addr(row_index, col_index);
    assign wr_elem = to_elem(elem_value);

    // Term addresses: A walks along the row, B down the column
    assign a_raddr = elem_addr(req_row_reg, IDX_BITS'(k_reg));
    assign b_raddr = elem_addr(IDX_BITS'(k_reg), req_col_reg);

    mpe_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (cmd.wr_a && a_in_range),
        .waddr (wr_addr),
        .wdata (wr_elem),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mpe_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (cmd.wr_b && b_in_range),
        .waddr (wr_addr),
        .wdata (wr_elem),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Request latch and term counter
    always_ff @(posedge clk)
    begin
        if (cmd.start_read)
        begin
            req_row_reg <= row_index;
            req_col_reg <= col_index;
            oob_reg     <= req_oob;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cmd.start_read)
        begin
            k_reg <= '0;
        end
        else if (cmd.issue)
        begin
            k_reg <= k_reg + DIM_BITS'(1);
        end
    end

    // Term pipeline valid flags: RAM read, then product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            data_v_reg <= cmd.issue;
            prod_v_reg <= data_v_reg;
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(a_rdata) * $signed(b_rdata);
        if (cmd.start_read)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + to_acc(prod_reg);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row       <= req_row_reg;
            out_col       <= req_col_reg;
            product_value <= $signed(acc_reg);
            status        <= oob_reg;
        end
    end

    // Status to the controller
    assign sts.skip      = req_oob || (nk == '0);
    assign sts.last_term = (SIZE_BITS'(k_reg) == (nk - SIZE_BITS'(1)));
    assign sts.pipe_busy = data_v_reg || prod_v_reg;

endmodule

`default_nettype wire

// ===== rtl/mpe_ctrl.sv =====
// Controller: request decode, term sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none

module mpe_ctrl import mpe_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic [OP_BITS-1:0] req_op,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output mpe_cmd_t                cmd,
    input  wire mpe_sts_t           sts
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.wr_a       = accept && (req_op == OP_WR_A);
        cmd.wr_b       = accept && (req_op == OP_WR_B);
        cmd.start_read = accept && (req_op == OP_READ);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start_read)
                begin
                    state_next = sts.skip ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_term)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.pipe_busy && out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/matrix_product_engine_unit.sv =====
// Top level of the matrix product engine: controller plus datapath.
//
//   channel | dir | beat carries
//   --------+-----+---------------------------------------------------
//   req     | in  | op, row_index, col_index, elem_value
//   rsp     | out | out_row, out_col, product_value, status
//   cfg     | in  | reg_index (0 rows_a, 1 inner_dim, 2 cols_b), reg_data
//
// An in-range product read runs one multiply-accumulate per term over inner_dim
// terms, with inner_dim capped at 16, fed by one read port on each element RAM,
// through the RAM read, multiplier and accumulator stages. A read outside the
// sizes, or with inner_dim zero, runs no terms.
// Reset sets all sizes to 16; element storage is not cleared. A finished result
// sits in the output register while the next request is taken; only loading a new
// result waits on rsp.ready.
`timescale 1ns / 1ps
`default_nettype none

module matrix_product_engine_unit import mpe_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    mpe_req_if.sink   req,
    mpe_rsp_if.source rsp,
    mpe_cfg_if.sink   cfg
);

    mpe_cmd_t cmd;
    mpe_sts_t sts;

    mpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mpe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_index     (req.row_index),
        .col_index     (req.col_index),
        .elem_value    (req.elem_value),
        .out_row       (rsp.out_row),
        .out_col       (rsp.out_col),
        .product_value (rsp.product_value),
        .status        (rsp.status),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire
